// ===== design/lsvp_pkg.sv =====
// lsvp_pkg: shared widths, register indexes, reset values and types for the
// lane segment select / vanishing point block
// no dependencies
package lsvp_pkg;

   // field and datapath widths
   localparam int COORD_W    = 12;                   // endpoint coordinate
   localparam int CFG_W      = 13;                   // config register width
   localparam int DIFF_W     = COORD_W + 1;          // signed coordinate difference
   localparam int SLOPE_FRAC = 10;                   // fraction bits of slope_limit
   localparam int CMP_W      = DIFF_W + SLOPE_FRAC + 5;
   localparam int MAC_A_W    = 26;                   // wide multiplier operand
   localparam int MAC_B_W    = 14;                   // narrow multiplier operand
   localparam int ACC_W      = MAC_A_W + MAC_B_W;    // accumulator
   localparam int DET_W      = 2 * DIFF_W + 1;       // determinant
   localparam int CROSS_W    = 2 * COORD_W + 1;      // line constant x1*y2-y1*x2
   localparam int NUM_W      = ACC_W;                // dividend
   localparam int VAN_W      = 16;                   // vanishing point coordinate
   localparam int QF_W       = NUM_W + 1;            // signed floor quotient
   localparam int DIV_CNT_W  = $clog2(NUM_W);

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_LIMIT = 1'd1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST = 13'd640;
   localparam logic [CFG_W-1:0] SLOPE_LIMIT_RST = 13'd307;

   typedef struct packed {
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
      logic [COORD_W-1:0] x2;
      logic [COORD_W-1:0] y2;
   } seg_type;

   // multiply-accumulate control
   typedef struct packed {
      logic en;    // update accumulator
      logic clr;   // start a new sum
      logic sub;   // subtract the product
   } mac_ctrl_type;

endpackage

// ===== design/lsvp_req_if.sv =====
// lsvp_req_if: segment transaction channel, valid/ready with payload
// depends on lsvp_pkg
interface lsvp_req_if import lsvp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] end_x;
   logic [COORD_W-1:0] end_y;
   logic               frame_end;

   modport source (output valid, start_x, start_y, end_x, end_y, frame_end, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, frame_end, output ready);
endinterface

// ===== design/lsvp_rsp_if.sv =====
// lsvp_rsp_if: frame result transaction channel, valid/ready with payload
// depends on lsvp_pkg
interface lsvp_rsp_if import lsvp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [COORD_W-1:0]      left_x1;
   logic [COORD_W-1:0]      left_y1;
   logic [COORD_W-1:0]      left_x2;
   logic [COORD_W-1:0]      left_y2;
   logic [COORD_W-1:0]      right_x1;
   logic [COORD_W-1:0]      right_y1;
   logic [COORD_W-1:0]      right_x2;
   logic [COORD_W-1:0]      right_y2;
   logic signed [VAN_W-1:0] vanish_x;
   logic signed [VAN_W-1:0] vanish_y;
   logic                    lines_parallel;

   modport source (output valid, left_x1, left_y1, left_x2, left_y2, right_x1, right_y1,
                   right_x2, right_y2, vanish_x, vanish_y, lines_parallel, input ready);
   modport sink   (input valid, left_x1, left_y1, left_x2, left_y2, right_x1, right_y1,
                   right_x2, right_y2, vanish_x, vanish_y, lines_parallel, output ready);
endinterface

// ===== design/lsvp_mac.sv =====
// lsvp_mac: shared signed multiply-accumulate unit, one product per cycle
// depends on lsvp_pkg
module lsvp_mac import lsvp_pkg::*; (
   input  logic                      clock,
   input  mac_ctrl_type              ctrl,
   input  logic signed [MAC_A_W-1:0] op_a,
   input  logic signed [MAC_B_W-1:0] op_b,
   output logic signed [ACC_W-1:0]   acc
);

   logic signed [ACC_W-1:0] prod;
   logic signed [ACC_W-1:0] base;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   assign prod = op_a * op_b;

   always_comb begin
      base   = ctrl.clr ? '0 : acc_ff;
      acc_in = acc_ff;
      if (ctrl.en) begin
         acc_in = ctrl.sub ? base - prod : base + prod;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== design/lsvp_div.sv =====
// lsvp_div: radix-2 restoring divider, one quotient bit per cycle, then
// floor fix-up, round to nearest (ties to even) and 16-bit saturation
// depends on lsvp_pkg
module lsvp_div import lsvp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DET_W-1:0] den,
   output logic                    busy,
   output logic                    done,
   output logic signed [VAN_W-1:0] quo
);

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX, D_RND} div_state_type;

   div_state_type           st_ff, st_in;
   logic [DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DET_W-1:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]        q_ff, q_in;
   logic [DET_W-1:0]        dabs_ff, dabs_in;
   logic                    neg_ff, neg_in;
   logic signed [QF_W-1:0]  qf_ff, qf_in;
   logic [DET_W-1:0]        rf_ff, rf_in;
   logic                    done_ff, done_in;
   logic signed [VAN_W-1:0] quo_ff, quo_in;

   logic [DET_W:0]          sh;
   logic [DET_W:0]          sh_sub;
   logic                    ge;
   logic                    nz;
   logic signed [QF_W-1:0]  qext;
   logic [DET_W:0]          rf2;
   logic                    up;
   logic signed [QF_W:0]    qr;

   always_comb begin
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dabs_in = dabs_ff;
      neg_in  = neg_ff;
      qf_in   = qf_ff;
      rf_in   = rf_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;

      sh     = {rem_ff, q_ff[NUM_W-1]};
      sh_sub = sh - {1'b0, dabs_ff};
      ge     = sh >= {1'b0, dabs_ff};
      nz     = rem_ff != '0;
      qext   = {1'b0, q_ff};
      rf2    = {rf_ff, 1'b0};
      up     = (rf2 > {1'b0, dabs_ff}) || ((rf2 == {1'b0, dabs_ff}) && qf_ff[0]);
      qr     = {qf_ff[QF_W-1], qf_ff} + {{QF_W{1'b0}}, up};

      unique case (st_ff)
         D_IDLE: begin
            if (start) begin
               q_in    = num[NUM_W-1] ? -num : num;
               dabs_in = den[DET_W-1] ? -den : den;
               neg_in  = num[NUM_W-1] ^ den[DET_W-1];
               rem_in  = '0;
               cnt_in  = DIV_CNT_W'(NUM_W - 1);
               st_in   = D_RUN;
            end
         end
         D_RUN: begin
            rem_in = ge ? sh_sub[DET_W-1:0] : sh[DET_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = D_FIX;
            end
         end
         D_FIX: begin
            // turn truncated magnitude into floor quotient, remainder >= 0
            if (neg_ff) begin
               qf_in = -(qext + {{(QF_W-1){1'b0}}, nz});
            end else begin
               qf_in = qext;
            end
            rf_in = (neg_ff && nz) ? dabs_ff - rem_ff : rem_ff;
            st_in = D_RND;
         end
         D_RND: begin
            if (qr > $signed((QF_W+1)'(32767))) begin
               quo_in = 16'sh7fff;
            end else if (qr < -$signed((QF_W+1)'(32768))) begin
               quo_in = 16'sh8000;
            end else begin
               quo_in = qr[VAN_W-1:0];
            end
            done_in = 1'b1;
            st_in   = D_IDLE;
         end
         default: st_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= D_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      dabs_ff <= dabs_in;
      neg_ff  <= neg_in;
      qf_ff   <= qf_in;
      rf_ff   <= rf_in;
      quo_ff  <= quo_in;
   end

   assign busy = st_ff != D_IDLE;
   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== design/lane_segment_select_vanishing_point_top.sv =====
// lane_segment_select_vanishing_point_top: per-frame left/right lane segment
// selection and vanishing point, with one shared multiplier and one divider
// depends on lsvp_pkg, lsvp_req_if, lsvp_rsp_if, lsvp_mac, lsvp_div
// a segment without frame_end passes the accept, slope product and judge steps;
// a frame_end segment then runs the multiplier schedule and, when the lines
// cross, two divisions (x, then y); parallel lines skip both divisions
// one segment in flight at a time; req ready only when the sequencer is idle
// reset: synchronous, frame_width 640, slope_limit 307, both kept segments zero
module lane_segment_select_vanishing_point_top import lsvp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   lsvp_req_if.sink             req_bus,
   lsvp_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_SLOPE, S_JUDGE, S_CALC, S_DIVX, S_WAITX, S_DIVY, S_WAITY, S_EMIT
   } state_type;

   // multiplier schedule for the intersection
   typedef enum logic [3:0] {
      ST_DET_A, ST_DET_B, ST_CA_A, ST_CA_B, ST_CB_A, ST_CB_B,
      ST_NX_A, ST_NX_B, ST_NY_A, ST_NY_B, ST_DONE
   } step_type;

   state_type                 state_ff, state_in;
   step_type                  step_ff, step_in;
   seg_type                   seg_ff, seg_in;
   logic                      end_ff, end_in;
   seg_type                   left_seg_ff, left_seg_in;
   seg_type                   right_seg_ff, right_seg_in;
   logic [COORD_W-1:0]        left_ctr_ff, left_ctr_in;
   logic [CFG_W-1:0]          right_ctr_ff, right_ctr_in;
   logic [CFG_W-1:0]          frame_width_ff, frame_width_in;
   logic [CFG_W-1:0]          slope_limit_ff, slope_limit_in;
   logic signed [DET_W-1:0]   d_ff, d_in;
   logic signed [CROSS_W-1:0] ca_ff, ca_in;
   logic signed [CROSS_W-1:0] cb_ff, cb_in;
   logic signed [NUM_W-1:0]   nx_ff, nx_in;
   logic signed [NUM_W-1:0]   ny_ff, ny_in;
   logic signed [VAN_W-1:0]   vx_ff, vx_in;
   logic signed [VAN_W-1:0]   vy_ff, vy_in;
   logic                      par_ff, par_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   seg_type                   out_left_ff, out_left_in;
   seg_type                   out_right_ff, out_right_in;
   logic signed [VAN_W-1:0]   out_vx_ff, out_vx_in;
   logic signed [VAN_W-1:0]   out_vy_ff, out_vy_in;
   logic                      out_par_ff, out_par_in;

   // shared multiplier and divider hookup
   mac_ctrl_type              mac_ctrl;
   logic signed [MAC_A_W-1:0] mac_a;
   logic signed [MAC_B_W-1:0] mac_b;
   logic signed [ACC_W-1:0]   mac_acc;
   logic                      div_start;
   logic signed [NUM_W-1:0]   div_num;
   logic                      div_busy;
   logic                      div_done;
   logic signed [VAN_W-1:0]   div_quo;

   // segment judging
   logic signed [DIFF_W-1:0]  dx, dy;
   logic signed [CMP_W-1:0]   lhs, rhs, cmp_sum, cmp_dif;
   logic                      steep_neg, steep_pos;
   logic [DIFF_W-1:0]         ctr_sum;
   logic [COORD_W-1:0]        center, mid;

   // kept-segment direction vectors
   logic signed [DIFF_W-1:0]  ax, ay, bx, by;

   lsvp_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   lsvp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (d_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_bus.ready = state_ff == S_IDLE;
   assign div_num       = (state_ff == S_DIVX) ? nx_ff : ny_ff;

   always_comb begin
      // slope test by cross-multiplication: dy * 2^frac against limit * dx
      dx      = {1'b0, seg_ff.x2} - {1'b0, seg_ff.x1};
      dy      = {1'b0, seg_ff.y2} - {1'b0, seg_ff.y1};
      lhs     = {{(CMP_W-DIFF_W-SLOPE_FRAC){dy[DIFF_W-1]}}, dy, {SLOPE_FRAC{1'b0}}};
      rhs     = mac_acc[CMP_W-1:0];
      cmp_sum = lhs + rhs;
      cmp_dif = lhs - rhs;
      if (dx > 0) begin
         steep_neg = cmp_sum < 0;
         steep_pos = cmp_dif > 0;
      end else if (dx < 0) begin
         steep_neg = cmp_sum > 0;
         steep_pos = cmp_dif < 0;
      end else begin
         // vertical segment: sign of dy only
         steep_neg = dy < 0;
         steep_pos = dy > 0;
      end
      ctr_sum = {1'b0, seg_ff.x1} + {1'b0, seg_ff.x2};
      center  = ctr_sum[DIFF_W-1:1];
      mid     = frame_width_ff[CFG_W-1:1];

      ax = {1'b0, left_seg_ff.x1} - {1'b0, left_seg_ff.x2};
      ay = {1'b0, left_seg_ff.y1} - {1'b0, left_seg_ff.y2};
      bx = {1'b0, right_seg_ff.x1} - {1'b0, right_seg_ff.x2};
      by = {1'b0, right_seg_ff.y1} - {1'b0, right_seg_ff.y2};
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      seg_in         = seg_ff;
      end_in         = end_ff;
      left_seg_in    = left_seg_ff;
      right_seg_in   = right_seg_ff;
      left_ctr_in    = left_ctr_ff;
      right_ctr_in   = right_ctr_ff;
      frame_width_in = frame_width_ff;
      slope_limit_in = slope_limit_ff;
      d_in           = d_ff;
      ca_in          = ca_ff;
      cb_in          = cb_ff;
      nx_in          = nx_ff;
      ny_in          = ny_ff;
      vx_in          = vx_ff;
      vy_in          = vy_ff;
      par_in         = par_ff;
      out_left_in    = out_left_ff;
      out_right_in   = out_right_ff;
      out_vx_in      = out_vx_ff;
      out_vy_in      = out_vy_ff;
      out_par_in     = out_par_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      mac_ctrl       = '0;
      mac_a          = '0;
      mac_b          = '0;
      div_start      = 1'b0;

      // register writes take effect at the next edge
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: frame_width_in = csr_wdata;
            CSR_SLOPE_LIMIT: slope_limit_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               seg_in.x1 = req_bus.start_x;
               seg_in.y1 = req_bus.start_y;
               seg_in.x2 = req_bus.end_x;
               seg_in.y2 = req_bus.end_y;
               end_in    = req_bus.frame_end;
               state_in  = S_SLOPE;
            end
         end
         S_SLOPE: begin
            // limit * dx into the accumulator
            mac_ctrl = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
            mac_a    = {{(MAC_A_W-DIFF_W){dx[DIFF_W-1]}}, dx};
            mac_b    = {{(MAC_B_W-CFG_W){1'b0}}, slope_limit_ff};
            state_in = S_JUDGE;
         end
         S_JUDGE: begin
            // strict improvement only, so the first of equal centers stays
            if (steep_neg && (center < mid)) begin
               if (center > left_ctr_ff) begin
                  left_ctr_in = center;
                  left_seg_in = seg_ff;
               end
            end else if (steep_pos && (center > mid)) begin
               if ({1'b0, center} < right_ctr_ff) begin
                  right_ctr_in = {1'b0, center};
                  right_seg_in = seg_ff;
               end
            end
            step_in  = ST_DET_A;
            state_in = end_ff ? S_CALC : S_IDLE;
         end
         S_CALC: begin
            step_in = step_type'(step_ff + 4'd1);
            case (step_ff)
               ST_DET_A: begin
                  mac_ctrl = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                  mac_a    = {{(MAC_A_W-DIFF_W){ax[DIFF_W-1]}}, ax};
                  mac_b    = {{(MAC_B_W-DIFF_W){by[DIFF_W-1]}}, by};
               end
               ST_DET_B: begin
                  mac_ctrl = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
                  mac_a    = {{(MAC_A_W-DIFF_W){ay[DIFF_W-1]}}, ay};
                  mac_b    = {{(MAC_B_W-DIFF_W){bx[DIFF_W-1]}}, bx};
               end
               ST_CA_A: begin
                  d_in     = mac_acc[DET_W-1:0];
                  mac_ctrl = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                  mac_a    = {{(MAC_A_W-COORD_W){1'b0}}, left_seg_ff.x1};
                  mac_b    = {{(MAC_B_W-COORD_W){1'b0}}, left_seg_ff.y2};
               end
               ST_CA_B: begin
                  mac_ctrl = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
                  mac_a    = {{(MAC_A_W-COORD_W){1'b0}}, left_seg_ff.y1};
                  mac_b    = {{(MAC_B_W-COORD_W){1'b0}}, left_seg_ff.x2};
               end
               ST_CB_A: begin
                  ca_in    = mac_acc[CROSS_W-1:0];
                  mac_ctrl = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                  mac_a    = {{(MAC_A_W-COORD_W){1'b0}}, right_seg_ff.x1};
                  mac_b    = {{(MAC_B_W-COORD_W){1'b0}}, right_seg_ff.y2};
               end
               ST_CB_B: begin
                  mac_ctrl = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
                  mac_a    = {{(MAC_A_W-COORD_W){1'b0}}, right_seg_ff.y1};
                  mac_b    = {{(MAC_B_W-COORD_W){1'b0}}, right_seg_ff.x2};
               end
               ST_NX_A: begin
                  cb_in    = mac_acc[CROSS_W-1:0];
                  mac_ctrl = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                  mac_a    = {{(MAC_A_W-CROSS_W){ca_ff[CROSS_W-1]}}, ca_ff};
                  mac_b    = {{(MAC_B_W-DIFF_W){bx[DIFF_W-1]}}, bx};
               end
               ST_NX_B: begin
                  mac_ctrl = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
                  mac_a    = {{(MAC_A_W-CROSS_W){cb_ff[CROSS_W-1]}}, cb_ff};
                  mac_b    = {{(MAC_B_W-DIFF_W){ax[DIFF_W-1]}}, ax};
               end
               ST_NY_A: begin
                  nx_in    = mac_acc;
                  mac_ctrl = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                  mac_a    = {{(MAC_A_W-CROSS_W){ca_ff[CROSS_W-1]}}, ca_ff};
                  mac_b    = {{(MAC_B_W-DIFF_W){by[DIFF_W-1]}}, by};
               end
               ST_NY_B: begin
                  mac_ctrl = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
                  mac_a    = {{(MAC_A_W-CROSS_W){cb_ff[CROSS_W-1]}}, cb_ff};
                  mac_b    = {{(MAC_B_W-DIFF_W){ay[DIFF_W-1]}}, ay};
               end
               default: begin
                  // products done; zero determinant skips both divisions
                  ny_in   = mac_acc;
                  step_in = ST_DET_A;
                  par_in  = d_ff == '0;
                  if (d_ff == '0) begin
                     vx_in    = -16'sd1;
                     vy_in    = -16'sd1;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_DIVX;
                  end
               end
            endcase
         end
         S_DIVX: begin
            div_start = 1'b1;
            state_in  = S_WAITX;
         end
         S_WAITX: begin
            if (div_done) begin
               vx_in    = div_quo;
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            div_start = 1'b1;
            state_in  = S_WAITY;
         end
         S_WAITY: begin
            if (div_done) begin
               vy_in    = div_quo;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the output register is free, then clear for next frame
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_left_in  = left_seg_ff;
               out_right_in = right_seg_ff;
               out_vx_in    = vx_ff;
               out_vy_in    = vy_ff;
               out_par_in   = par_ff;
               rsp_valid_in = 1'b1;
               left_seg_in  = '0;
               right_seg_in = '0;
               left_ctr_in  = '0;
               right_ctr_in = frame_width_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         step_ff        <= ST_DET_A;
         left_seg_ff    <= '0;
         right_seg_ff   <= '0;
         left_ctr_ff    <= '0;
         right_ctr_ff   <= FRAME_WIDTH_RST;
         frame_width_ff <= FRAME_WIDTH_RST;
         slope_limit_ff <= SLOPE_LIMIT_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         left_seg_ff    <= left_seg_in;
         right_seg_ff   <= right_seg_in;
         left_ctr_ff    <= left_ctr_in;
         right_ctr_ff   <= right_ctr_in;
         frame_width_ff <= frame_width_in;
         slope_limit_ff <= slope_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      seg_ff       <= seg_in;
      end_ff       <= end_in;
      d_ff         <= d_in;
      ca_ff        <= ca_in;
      cb_ff        <= cb_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      par_ff       <= par_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_vx_ff    <= out_vx_in;
      out_vy_ff    <= out_vy_in;
      out_par_ff   <= out_par_in;
   end

   // result transaction
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.left_x1        = out_left_ff.x1;
   assign rsp_bus.left_y1        = out_left_ff.y1;
   assign rsp_bus.left_x2        = out_left_ff.x2;
   assign rsp_bus.left_y2        = out_left_ff.y2;
   assign rsp_bus.right_x1       = out_right_ff.x1;
   assign rsp_bus.right_y1       = out_right_ff.y1;
   assign rsp_bus.right_x2       = out_right_ff.x2;
   assign rsp_bus.right_y2       = out_right_ff.y2;
   assign rsp_bus.vanish_x       = out_vx_ff;
   assign rsp_bus.vanish_y       = out_vy_ff;
   assign rsp_bus.lines_parallel = out_par_ff;

   // a new result only comes out of the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result valid rose outside emit");

   // parallel lines always report (-1,-1)
   a_parallel_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_par_ff |-> (out_vx_ff == -16'sd1) && (out_vy_ff == -16'sd1))
      else $error("parallel result with a vanishing point");

   // left center zero means no left candidate was kept
   a_left_empty: assert property (@(posedge clock) disable iff (reset)
      (left_ctr_ff == '0) |-> (left_seg_ff == '0))
      else $error("left segment kept without a center");

   // divider is never restarted mid-division
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

endmodule
